// ===== sv/olidd_pkg.sv =====
// olidd_pkg: shared types and constants for the ordered list unit.
// Holds command codes, field widths and the controller/datapath interface structs.
// No dependencies.
package olidd_pkg;

	localparam int VAL_W = 32;
	localparam int POS_W = 8;
	localparam int CMD_W = 2;

	localparam logic [CMD_W-1:0] CMD_INS_FRONT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INS_BACK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE    = 2'd2;

	typedef struct packed {
		logic load;
		logic shift;
		logic shift_fin;
		logic dump_init;
		logic dump;
	} ctl_cmd_t;

	typedef struct packed {
		logic need_shift;
		logic shift_done;
		logic dump_done;
	} ctl_sts_t;

endpackage

// ===== sv/olidd_ram.sv =====
// olidd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module olidd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/olidd_ctrl.sv =====
// olidd_ctrl: command sequencer for the ordered list unit.
// Steps accept, delete shift and dump phases; depends on olidd_pkg.
module olidd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  olidd_pkg::ctl_sts_t sts,
	output olidd_pkg::ctl_cmd_t ctl
);
	import olidd_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SHIFT = 2'd1;
	localparam logic [1:0] ST_DUMP  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		ctl       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					ctl.load = 1'b1;
					if (sts.need_shift) begin
						state_nxt = ST_SHIFT;
					end else begin
						ctl.dump_init = 1'b1;
						state_nxt     = ST_DUMP;
					end
				end
			end
			ST_SHIFT: begin
				ctl.shift = 1'b1;
				if (sts.shift_done) begin
					ctl.shift_fin = 1'b1;
					ctl.dump_init = 1'b1;
					state_nxt     = ST_DUMP;
				end
			end
			ST_DUMP: begin
				ctl.dump = 1'b1;
				if (sts.dump_done) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== sv/olidd_dp.sv =====
// olidd_dp: datapath of the ordered list unit: circular store, count, front slot,
// delete shift and dump read-out. Depends on olidd_pkg and olidd_ram.
module olidd_dp #(
	parameter int CAPACITY = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  olidd_pkg::ctl_cmd_t           ctl,
	output olidd_pkg::ctl_sts_t           sts,
	input  logic [olidd_pkg::CMD_W-1:0]   in_cmd,
	input  logic [olidd_pkg::VAL_W-1:0]   in_value,
	input  logic [olidd_pkg::POS_W-1:0]   in_pos,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [olidd_pkg::VAL_W-1:0]   element,
	output logic                          is_last,
	output logic                          list_empty,
	output logic                          insert_dropped
);
	import olidd_pkg::*;

	localparam int SW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int SUMW = CW + 1;

	function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] fr,
	                                          input logic [CW-1:0] off);
		logic [SUMW-1:0] s;
		s = SUMW'(fr) + SUMW'(off);
		if (s >= SUMW'(CAPACITY)) begin
			s = s - SUMW'(CAPACITY);
		end
		return s[SW-1:0];
	endfunction

	logic [CW-1:0] count_q;
	logic [SW-1:0] front_q;
	logic [CW-1:0] idx_q;
	logic [SW-1:0] wa_q;
	logic          pend_q;
	logic          iss_done_q;
	logic          mvalid_q;
	logic          last_q;
	logic          empty_q;
	logic          dropped_q;

	logic [VAL_W-1:0] rdata;
	logic             we;
	logic [SW-1:0]    waddr;
	logic [VAL_W-1:0] wdata;
	logic             re;
	logic [SW-1:0]    raddr;

	logic            is_ins;
	logic            full;
	logic            ins_ok;
	logic [7:0]      pos_u;
	logic            del_ok;
	logic            del_front;
	logic [SW-1:0]   front_dec;
	logic [SUMW-1:0] idx_inc;
	logic            more_shift;
	logic            shift_rd;
	logic            adv;
	logic            dump_rd;
	logic            dump_iss;

	assign is_ins    = (in_cmd == CMD_INS_FRONT) || (in_cmd == CMD_INS_BACK);
	assign full      = (count_q == CW'(CAPACITY));
	assign ins_ok    = is_ins && !full;
	assign pos_u     = {1'b0, in_pos[6:0]};
	assign del_ok    = (in_cmd == CMD_DELETE) && !in_pos[7] && (pos_u < 8'(count_q));
	assign del_front = (pos_u == 8'd0);
	assign front_dec = (front_q == '0) ? SW'(CAPACITY - 1) : front_q - SW'(1);

	assign sts.need_shift = del_ok && !del_front && ((pos_u + 8'd1) < 8'(count_q));

	assign idx_inc    = SUMW'(idx_q) + SUMW'(1);
	assign more_shift = idx_inc < SUMW'(count_q);
	assign shift_rd   = ctl.shift && more_shift;
	assign sts.shift_done = !more_shift && !pend_q;

	assign adv      = !mvalid_q || m_tready;
	assign dump_iss = ctl.dump && adv && !iss_done_q;
	assign dump_rd  = dump_iss && (count_q != '0);
	assign sts.dump_done = ctl.dump && iss_done_q && mvalid_q && m_tready;

	always_comb begin
		we    = 1'b0;
		waddr = wa_q;
		wdata = rdata;
		if (ctl.load && ins_ok) begin
			we    = 1'b1;
			waddr = (in_cmd == CMD_INS_FRONT) ? front_dec : slot_of(front_q, count_q);
			wdata = in_value;
		end else if (pend_q) begin
			we = 1'b1;
		end
	end

	assign re    = shift_rd || dump_rd;
	assign raddr = ctl.shift ? slot_of(front_q, idx_inc[CW-1:0]) : slot_of(front_q, idx_q);

	olidd_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			front_q    <= '0;
			idx_q      <= '0;
			wa_q       <= '0;
			pend_q     <= 1'b0;
			iss_done_q <= 1'b0;
			mvalid_q   <= 1'b0;
			last_q     <= 1'b0;
			empty_q    <= 1'b0;
			dropped_q  <= 1'b0;
		end else begin
			pend_q <= shift_rd;
			if (shift_rd) begin
				wa_q <= slot_of(front_q, idx_q);
			end

			if (ctl.load) begin
				dropped_q <= is_ins && full;
				if (ins_ok) begin
					count_q <= count_q + CW'(1);
					if (in_cmd == CMD_INS_FRONT) begin
						front_q <= front_dec;
					end
				end else if (del_ok && !sts.need_shift) begin
					count_q <= count_q - CW'(1);
					if (del_front) begin
						front_q <= (count_q == CW'(1)) ? '0 : slot_of(front_q, CW'(1));
					end
				end
			end else if (ctl.shift_fin) begin
				count_q <= count_q - CW'(1);
			end

			if (ctl.load && sts.need_shift) begin
				idx_q <= in_pos[CW-1:0];
			end else if (ctl.dump_init) begin
				idx_q      <= '0;
				iss_done_q <= 1'b0;
			end else if (shift_rd) begin
				idx_q <= idx_inc[CW-1:0];
			end else if (dump_rd) begin
				idx_q <= idx_inc[CW-1:0];
			end

			if (dump_iss) begin
				mvalid_q <= 1'b1;
				if (count_q == '0) begin
					empty_q    <= 1'b1;
					last_q     <= 1'b1;
					iss_done_q <= 1'b1;
				end else begin
					empty_q    <= 1'b0;
					last_q     <= (idx_inc == SUMW'(count_q));
					iss_done_q <= (idx_inc == SUMW'(count_q));
				end
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid       = mvalid_q;
	assign element        = empty_q ? '0 : rdata;
	assign is_last        = last_q;
	assign list_empty     = empty_q;
	assign insert_dropped = dropped_q;

endmodule

// ===== sv/ordered_list_insert_delete_dump_unit.sv =====
// Ordered list unit: insert front/back or delete at position, then dump the list.
// Order: a middle delete (not at the front, not the last element) first shifts the later
// elements down one slot; then the list is dumped, each beat read from the store and registered.
// Throughput: one beat per cycle while dumping and the sink is ready; the element store
// has a single read port. Input is taken only when idle.
// Reset (arst_n low): count and front slot cleared, no beat pending; store contents undefined.
module ordered_list_insert_delete_dump_unit #(
	parameter int CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] item_value, [39:32] position
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] element
	output logic        m_tlast,
	output logic [1:0]  m_tuser    // [0] list_empty, [1] insert_dropped
);
	import olidd_pkg::*;

	ctl_cmd_t ctl;
	ctl_sts_t sts;
	logic     empty_flag;
	logic     dropped_flag;

	olidd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	olidd_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.in_cmd         (s_tuser),
		.in_value       (s_tdata[31:0]),
		.in_pos         (s_tdata[39:32]),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.element        (m_tdata),
		.is_last        (m_tlast),
		.list_empty     (empty_flag),
		.insert_dropped (dropped_flag)
	);

	assign m_tuser = {dropped_flag, empty_flag};

endmodule
